@@ rtl/core/ped_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types, character codes and helpers of the percent codec.
// ----------------------------------------------------------------------------
package ped_pkg;

  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_SLASH   = 8'h2F;
  localparam logic [7:0] CHR_TILDE   = 8'h7E;
  localparam logic [7:0] CHR_DASH    = 8'h2D;
  localparam logic [7:0] CHR_USCORE  = 8'h5F;
  localparam logic [7:0] CHR_DOT     = 8'h2E;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_UA      = 8'h41;
  localparam logic [7:0] CHR_UF      = 8'h46;
  localparam logic [7:0] CHR_UZ      = 8'h5A;
  localparam logic [7:0] CHR_LA      = 8'h61;
  localparam logic [7:0] CHR_LF      = 8'h66;
  localparam logic [7:0] CHR_LZ      = 8'h7A;
  localparam logic [7:0] NIBBLE_TEN  = 8'd10;

  // configuration register indexes
  localparam logic CFG_DIRECTION    = 1'b0;
  localparam logic CFG_ESCAPE_SLASH = 1'b1;

  // command codes between front and back
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_ESC  = 2'd1;
  localparam logic [1:0] OP_ERR  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       last;
  } ped_cmd_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHR_ZERO && c <= CHR_NINE) begin
      d = c - CHR_ZERO;
      return {1'b1, d[3:0]};
    end
    if (c >= CHR_LA && c <= CHR_LF) begin
      d = c - CHR_LA + NIBBLE_TEN;
      return {1'b1, d[3:0]};
    end
    if (c >= CHR_UA && c <= CHR_UF) begin
      d = c - CHR_UA + NIBBLE_TEN;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic passes_plain(input logic [7:0] c, input logic esc_slash);
    logic p;
    p = 1'b0;
    if (c >= CHR_UA && c <= CHR_UZ) p = 1'b1;
    if (c >= CHR_LA && c <= CHR_LZ) p = 1'b1;
    if (c >= CHR_ZERO && c <= CHR_NINE) p = 1'b1;
    if (c == CHR_DASH || c == CHR_USCORE || c == CHR_DOT || c == CHR_TILDE) p = 1'b1;
    if (c == CHR_SLASH && !esc_slash) p = 1'b1;
    return p;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'd0, v};
    return (w < NIBBLE_TEN) ? (CHR_ZERO + w) : (CHR_LA + w - NIBBLE_TEN);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ped_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ped_front
// Accepts input words, tracks escape and discard state, issues commands.
// ----------------------------------------------------------------------------
module ped_front
  import ped_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire logic [7:0] in_byte,
  input  wire logic     in_last,
  input  wire logic     direction,
  input  wire logic     escape_slash,
  output logic          cmd_we,
  output ped_cmd_t      cmd
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] high_r, high_nxt;
  logic       disc_r, disc_nxt;
  logic       emit;
  logic [4:0] hv;

  assign hv = hex_value(in_byte);

  always_comb begin
    phase_nxt = phase_r;
    high_nxt  = high_r;
    disc_nxt  = disc_r;
    emit      = 1'b0;
    cmd.op    = OP_BYTE;
    cmd.data  = in_byte;
    cmd.last  = in_last;
    if (!direction) begin
      phase_nxt = PH_IDLE;
      disc_nxt  = 1'b0;
      emit      = 1'b1;
      cmd.op    = passes_plain(in_byte, escape_slash) ? OP_BYTE : OP_ESC;
    end else if (disc_r) begin
      if (in_last) disc_nxt = 1'b0;
    end else if (phase_r == PH_PCT || phase_r == PH_HIGH) begin
      emit = 1'b1;
      if (!hv[4]) begin
        phase_nxt = PH_IDLE;
        disc_nxt  = !in_last;
        cmd.op    = OP_ERR;
      end else if (phase_r == PH_PCT) begin
        high_nxt = hv[3:0];
        if (in_last) begin
          phase_nxt = PH_IDLE;
          cmd.op    = OP_ERR;
        end else begin
          phase_nxt = PH_HIGH;
          emit      = 1'b0;
        end
      end else begin
        phase_nxt = PH_IDLE;
        cmd.data  = {high_r, hv[3:0]};
      end
    end else begin
      phase_nxt = PH_IDLE;
      emit      = 1'b1;
      if (in_byte == CHR_PERCENT) begin
        if (in_last) begin
          cmd.op = OP_ERR;
        end else begin
          phase_nxt = PH_PCT;
          emit      = 1'b0;
        end
      end else if (in_byte == CHR_PLUS) begin
        cmd.data = CHR_SPACE;
      end
    end
  end

  assign cmd_we = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      high_r  <= 4'd0;
      disc_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      high_r  <= high_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ped_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ped_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module ped_fifo
  import ped_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  wire ped_cmd_t wr_cmd,
  input  wire logic     rd_en,
  output ped_cmd_t      rd_cmd,
  output logic          full,
  output logic          not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ped_cmd_t      slot_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign rd_cmd    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (!wr_en && rd_en) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ped_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ped_back
// Expands commands into output words and holds the output register.
// ----------------------------------------------------------------------------
module ped_back
  import ped_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_valid,
  input  wire ped_cmd_t cmd,
  output logic          cmd_pop,
  input  wire logic     pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          bad_escape
);

  logic [1:0] sub_r;
  logic       vld_r;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       bad_r, bad_nxt;
  logic       load;

  assign load = cmd_valid && (!vld_r || pop);

  always_comb begin
    byte_nxt = cmd.data;
    last_nxt = cmd.last;
    bad_nxt  = 1'b0;
    cmd_pop  = load;
    case (cmd.op)
      OP_ESC: begin
        case (sub_r)
          2'd0: begin
            byte_nxt = CHR_PERCENT;
            last_nxt = 1'b0;
            cmd_pop  = 1'b0;
          end
          2'd1: begin
            byte_nxt = hex_digit(cmd.data[7:4]);
            last_nxt = 1'b0;
            cmd_pop  = 1'b0;
          end
          default: byte_nxt = hex_digit(cmd.data[3:0]);
        endcase
      end
      OP_ERR: begin
        byte_nxt = 8'd0;
        last_nxt = 1'b1;
        bad_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        sub_r <= cmd_pop ? 2'd0 : sub_r + 2'd1;
      end else if (pop) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign empty      = !vld_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign bad_escape = bad_r;

endmodule
`default_nettype wire

@@ rtl/core/percent_encode_decode_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// percent_encode_decode_core
// Percent encoder / decoder for byte strings.
// ----------------------------------------------------------------------------
// One input word per cycle while the command queue is not full. In encode mode
// a plain byte gives one output word; an escaped byte gives three words in turn
// at the output register, and input stalls once the FIFO_DEPTH command queue
// between the front and the expanding back end fills. In decode mode every
// byte gives at most one word, so the stream runs at one word per cycle
// while the sink keeps popping. With the queue empty, a word passes through
// the queue slot and then the output register before it can be popped.
// ----------------------------------------------------------------------------
module percent_encode_decode_core
  import ped_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            bad_escape,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data
);

  logic     direction_r;
  logic     esc_slash_r;
  logic     accept;
  logic     cmd_we;
  ped_cmd_t wr_cmd;
  ped_cmd_t rd_cmd;
  logic     cmd_valid;
  logic     cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      esc_slash_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION:    direction_r <= cfg_data;
        CFG_ESCAPE_SLASH: esc_slash_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  ped_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .direction    (direction_r),
    .escape_slash (esc_slash_r),
    .cmd_we       (cmd_we),
    .cmd          (wr_cmd)
  );

  ped_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cmd_we),
    .wr_cmd    (wr_cmd),
    .rd_en     (cmd_pop),
    .rd_cmd    (rd_cmd),
    .full      (full),
    .not_empty (cmd_valid)
  );

  ped_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (rd_cmd),
    .cmd_pop    (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .bad_escape (bad_escape)
  );

endmodule
`default_nettype wire

@@ sim/percent_encode_decode_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_encode_decode_core_test
// Self-checking bench for the percent encoder / decoder.
// ----------------------------------------------------------------------------
// Strings are queued one byte per word and pushed by a falling-edge driver;
// a falling-edge sink pops results. At each rising edge the monitor checks
// popped words against a behavioural codec and feeds accepted bytes into it.
// A short directed set comes first, then random strings under every register
// setting, with random stalls on both sides and a quiet tail at the end.
// ----------------------------------------------------------------------------
module percent_encode_decode_core_test
  import ped_pkg::*;
;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;

  localparam logic [7:0] PERCENT_C = 8'h25;
  localparam logic [7:0] PLUS_C    = 8'h2B;
  localparam logic [7:0] SPACE_C   = 8'h20;
  localparam logic [7:0] SLASH_C   = 8'h2F;

  typedef enum logic [1:0] {ESC_NONE, ESC_OPEN, ESC_HIGH} esc_phase_e;
  typedef enum int {PC_PLAIN, PC_PLUS, PC_ESCAPE, PC_BROKEN, PC_RAW} piece_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       bad_escape;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic       cfg_data = 1'b0;

  percent_encode_decode_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .bad_escape (bad_escape),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  in_word_t   text_bytes[$];
  out_word_t  codec_words[$];
  out_word_t  due_w;

  // codec state as seen by the bench
  logic       decoding = 1'b0;
  logic       slash_escaped = 1'b1;
  esc_phase_e esc_phase = ESC_NONE;
  logic [3:0] high_nib = 4'h0;
  logic       dropping = 1'b0;

  logic       stalls_on = 1'b1;
  int         push_gap = 0;
  int         pop_gap = 0;
  int         mismatches = 0;
  int         cycle_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - 8'h30);
    if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
    if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c, input logic esc_slash);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9"))
      return 1'b1;
    if (c == "-" || c == "_" || c == "." || c == "~") return 1'b1;
    return (c == SLASH_C) && !esc_slash;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] w;
    w = {4'h0, v};
    return (w < 8'd10) ? 8'h30 + w : 8'h61 + w - 8'd10;
  endfunction

  function automatic void push_word(input logic [7:0] b, input logic l, input logic e);
    codec_words.push_back({b, l, e});
  endfunction

  task automatic codec_step(input logic [7:0] c, input logic lst);
    int h;
    h = nibble_of(c);
    if (!decoding) begin
      esc_phase = ESC_NONE;
      dropping = 1'b0;
      if (is_unreserved(c, slash_escaped)) begin
        push_word(c, lst, 1'b0);
      end else begin
        push_word(PERCENT_C, 1'b0, 1'b0);
        push_word(hex_char(c[7:4]), 1'b0, 1'b0);
        push_word(hex_char(c[3:0]), lst, 1'b0);
      end
    end else if (dropping) begin
      if (lst) dropping = 1'b0;
    end else if (esc_phase == ESC_OPEN || esc_phase == ESC_HIGH) begin
      if (h < 0) begin
        esc_phase = ESC_NONE;
        dropping = !lst;
        push_word(8'h00, 1'b1, 1'b1);
      end else if (esc_phase == ESC_OPEN) begin
        high_nib = h[3:0];
        if (lst) begin
          esc_phase = ESC_NONE;
          push_word(8'h00, 1'b1, 1'b1);
        end else begin
          esc_phase = ESC_HIGH;
        end
      end else begin
        esc_phase = ESC_NONE;
        push_word({high_nib, h[3:0]}, lst, 1'b0);
      end
    end else begin
      esc_phase = ESC_NONE;
      if (c == PERCENT_C) begin
        if (lst) push_word(8'h00, 1'b1, 1'b1);
        else esc_phase = ESC_OPEN;
      end else begin
        push_word((c == PLUS_C) ? SPACE_C : c, lst, 1'b0);
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push_gap > 0) begin
      push_gap <= push_gap - 1;
      push <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      push_gap <= $urandom_range(0, 17);
      push <= 1'b0;
    end else if (text_bytes.size() != 0) begin
      push <= 1'b1;
      in_byte <= text_bytes[0].data;
      in_last <= text_bytes[0].last;
    end else begin
      push <= 1'b0;
    end
  end

  // result sink
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      pop_gap <= $urandom_range(0, 17);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // monitor: check popped words first, then predict from the accepted byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (codec_words.size() == 0) begin
          $error("unexpected word: out_byte %h out_last %b bad_escape %b",
                 out_byte, out_last, bad_escape);
          mismatches++;
        end else begin
          due_w = codec_words.pop_front();
          if (out_byte !== due_w.data) begin
            $error("out_byte mismatch: expected %h, actual %h", due_w.data, out_byte);
            mismatches++;
          end
          if (out_last !== due_w.last) begin
            $error("out_last mismatch: expected %b, actual %b", due_w.last, out_last);
            mismatches++;
          end
          if (bad_escape !== due_w.bad) begin
            $error("bad_escape mismatch: expected %b, actual %b", due_w.bad, bad_escape);
            mismatches++;
          end
        end
      end
      if (push && !full) begin
        void'(text_bytes.pop_front());
        codec_step(in_byte, in_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("percent_encode_decode_core verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_DIRECTION) decoding = val;
    else slash_escaped = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] c, input logic lst);
    text_bytes.push_back({c, lst});
  endtask

  task automatic queue_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++)
      queue_byte(s[i], close && (i == s.len() - 1));
  endtask

  task automatic drain();
    while (text_bytes.size() != 0 || codec_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] rand_plain();
    case ($urandom_range(0, 3))
      0: return 8'h41 + 8'($urandom_range(0, 25));
      1: return 8'h61 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      default: begin
        case ($urandom_range(0, 4))
          0: return "-";
          1: return "_";
          2: return ".";
          3: return "~";
          default: return SLASH_C;
        endcase
      end
    endcase
  endfunction

  // one string of mostly well-formed pieces; escapes may be cut by the end
  task automatic queue_string(input int len, output int n);
    logic [7:0] s[$];
    int         pick;
    piece_e     kind;
    while (s.size() < len) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 45) ? PC_PLAIN : (pick < 55) ? PC_PLUS :
             (pick < 75) ? PC_ESCAPE : (pick < 85) ? PC_BROKEN : PC_RAW;
      case (kind)
        PC_PLAIN:  s.push_back(rand_plain());
        PC_PLUS:   s.push_back(PLUS_C);
        PC_ESCAPE: begin
          s.push_back(PERCENT_C);
          s.push_back(rand_hex_char());
          s.push_back(rand_hex_char());
        end
        PC_BROKEN: begin
          s.push_back(PERCENT_C);
          case ($urandom_range(0, 3))
            0: s.push_back(rand_non_hex());
            1: begin
              s.push_back(rand_hex_char());
              s.push_back(rand_non_hex());
            end
            2: ;
            default: s.push_back(rand_hex_char());
          endcase
        end
        default: s.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    for (int i = 0; i < s.size(); i++) queue_byte(s[i], i == s.size() - 1);
    n = s.size();
  endtask

  initial begin : stimulus
    int queued;
    int len;
    int n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // encode with slash escaped: byte extremes, marks, high byte
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_text("~/Z", 1'b0);
    queue_byte(8'h80, 1'b1);
    drain();
    write_reg(CFG_ESCAPE_SLASH, 1'b0);
    queue_text("/%", 1'b1);
    drain();
    // decode: escapes, plus, bad escape with discard, cut-off escapes
    write_reg(CFG_DIRECTION, 1'b1);
    queue_text("%41+%fF", 1'b1);
    queue_text("%zqx", 1'b1);
    queue_text("%", 1'b1);
    queue_text("%a", 1'b1);
    queue_text("%", 1'b0);
    drain();
    // encode after an open escape must start clean
    write_reg(CFG_DIRECTION, 1'b0);
    queue_text("a", 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_DIRECTION, ph[0]);
      write_reg(CFG_ESCAPE_SLASH, ph[1]);
      stalls_on = (ph < 6);
      queued = 0;
      while (queued < 50) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        queue_string(len, n);
        queued += n;
      end
      drain();
    end

    if (mismatches == 0) $display("percent_encode_decode_core verification clean");
    else $display("percent_encode_decode_core verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ped_pkg.sv
rtl/core/ped_front.sv
rtl/core/ped_fifo.sv
rtl/core/ped_back.sv
rtl/core/percent_encode_decode_core.sv
sim/percent_encode_decode_core_test.sv
